// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property while out of reset
`define PAB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every edge, reset included
`define PAB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pab_pkg.sv =====
package pab_pkg;

    localparam int unsigned PAB_NCHAN = 4;

    typedef enum logic [2:0] {
        REG_RED_POS    = 3'd0,
        REG_RED_BITS   = 3'd1,
        REG_GREEN_POS  = 3'd2,
        REG_GREEN_BITS = 3'd3,
        REG_BLUE_POS   = 3'd4,
        REG_BLUE_BITS  = 3'd5,
        REG_ALPHA_POS  = 3'd6,
        REG_ALPHA_BITS = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2,
        CH_ALPHA = 2'd3
    } t_chan_idx;

    typedef struct packed {
        logic [4:0] pos;
        logic [3:0] bits;
    } t_chan_cfg;

    typedef t_chan_cfg [PAB_NCHAN-1:0] t_cfg;

    localparam t_cfg PAB_CFG_RESET = '{
        3: '{pos: 5'd24, bits: 4'd8},
        2: '{pos: 5'd0,  bits: 4'd8},
        1: '{pos: 5'd8,  bits: 4'd8},
        0: '{pos: 5'd16, bits: 4'd8}
    };

    localparam logic [7:0]  FULL_ALPHA   = 8'hFF;
    localparam logic [7:0]  ROUND_HALF   = 8'd127;
    // ceil(2^23 / 255): exact floor(x / 255) for x below 2^16
    localparam logic [15:0] DIV255_MUL   = 16'd32897;
    localparam int unsigned DIV255_SHIFT = 23;

    // 255 * ceil(2^24 / (2^n - 1)): exact floor(f * 255 / (2^n - 1))
    localparam logic [31:0] ExpK1 = 32'(64'd255 * ((64'd16777216 + 64'd0) / 64'd1));
    localparam logic [31:0] ExpK2 = 32'(64'd255 * ((64'd16777216 + 64'd2) / 64'd3));
    localparam logic [31:0] ExpK3 = 32'(64'd255 * ((64'd16777216 + 64'd6) / 64'd7));
    localparam logic [31:0] ExpK4 = 32'(64'd255 * ((64'd16777216 + 64'd14) / 64'd15));
    localparam logic [31:0] ExpK5 = 32'(64'd255 * ((64'd16777216 + 64'd30) / 64'd31));
    localparam logic [31:0] ExpK6 = 32'(64'd255 * ((64'd16777216 + 64'd62) / 64'd63));
    localparam logic [31:0] ExpK7 = 32'(64'd255 * ((64'd16777216 + 64'd126) / 64'd127));

    typedef struct packed {
        logic [2:0][7:0] old_chan;
        logic [31:0]     src;
        logic [7:0]      alpha;
    } t_unp;

    typedef struct packed {
        logic [PAB_NCHAN-1:0][7:0] chan;
        logic                      zero;
    } t_mix;

    function automatic logic [7:0] chan_mask(input logic [3:0] n);
        logic [8:0] m;
        begin
            m = (9'd1 << n[2:0]) - 9'd1;
            chan_mask = n[3] ? 8'hFF : m[7:0];
        end
    endfunction

    function automatic logic [31:0] exp_coef(input logic [3:0] n);
        case (n)
            4'd1:    exp_coef = ExpK1;
            4'd2:    exp_coef = ExpK2;
            4'd3:    exp_coef = ExpK3;
            4'd4:    exp_coef = ExpK4;
            4'd5:    exp_coef = ExpK5;
            4'd6:    exp_coef = ExpK6;
            4'd7:    exp_coef = ExpK7;
            default: exp_coef = 32'd0;
        endcase
    endfunction

endpackage

// ===== rtl/pab_unpack.sv =====
module pab_unpack (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pab_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [31:0]    i_old_pixel,
    input  logic [31:0]    i_src_color,
    input  logic [7:0]     i_blend_alpha,
    output logic           o_valid,
    input  logic           i_stall,
    output pab_pkg::t_unp  o_word
);

    logic        r_a_valid;
    logic [7:0]  r_a_f [3];
    logic [31:0] r_a_src;
    logic [7:0]  r_a_alpha;
    logic        r_b_valid;
    pab_pkg::t_unp r_b_word;

    logic        w_rdy_a;
    logic        w_rdy_b;
    logic [7:0]  n_a_f [3];
    logic [7:0]  n_b_exp [3];
    logic [39:0] w_prod [3];
    logic [31:0] w_shift [3];

    assign w_rdy_b = !r_b_valid || !i_stall;
    assign w_rdy_a = !r_a_valid || w_rdy_b;
    assign o_stall = !w_rdy_a;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_shift[c] = i_old_pixel >> i_cfg[c].pos;
            n_a_f[c]   = w_shift[c][7:0] & pab_pkg::chan_mask(i_cfg[c].bits);
            w_prod[c]  = 40'(r_a_f[c]) * 40'(pab_pkg::exp_coef(i_cfg[c].bits));
            if (i_cfg[c].bits[3]) begin
                n_b_exp[c] = r_a_f[c];
            end else begin
                n_b_exp[c] = w_prod[c][31:24];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_rdy_a) r_a_valid <= i_valid;
            if (w_rdy_b) r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_f     <= n_a_f;
            r_a_src   <= i_src_color;
            r_a_alpha <= i_blend_alpha;
        end
        if (w_rdy_b) begin
            for (int c = 0; c < 3; c++) r_b_word.old_chan[c] <= n_b_exp[c];
            r_b_word.src   <= r_a_src;
            r_b_word.alpha <= r_a_alpha;
        end
    end

    assign o_valid = r_b_valid;
    assign o_word  = r_b_word;

endmodule

// ===== rtl/pab_blend.sv =====
module pab_blend (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  pab_pkg::t_unp  i_word,
    output logic           o_valid,
    input  logic           i_stall,
    output pab_pkg::t_mix  o_word
);

    logic        r_c_valid;
    logic [15:0] r_c_sum [3];
    logic [31:0] r_c_src;
    logic [7:0]  r_c_alpha;
    logic        r_d_valid;
    pab_pkg::t_mix r_d_word;

    logic        w_rdy_c;
    logic        w_rdy_d;
    logic [7:0]  w_inv;
    logic [15:0] w_ps [3];
    logic [15:0] w_po [3];
    logic [15:0] n_c_sum [3];
    logic [31:0] w_q [3];
    pab_pkg::t_mix n_d_word;

    assign w_rdy_d = !r_d_valid || !i_stall;
    assign w_rdy_c = !r_c_valid || w_rdy_d;
    assign o_stall = !w_rdy_c;
    assign w_inv   = 8'hFF - i_word.alpha;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_ps[c]    = 16'(i_word.src[8*(2-c) +: 8]) * 16'(i_word.alpha);
            w_po[c]    = 16'(i_word.old_chan[c]) * 16'(w_inv);
            n_c_sum[c] = 16'(17'(w_ps[c]) + 17'(w_po[c]));
            w_q[c]     = 32'(r_c_sum[c]) * 32'(pab_pkg::DIV255_MUL);
        end
        n_d_word.zero = (r_c_alpha == 8'd0);
        if (r_c_alpha == pab_pkg::FULL_ALPHA) begin
            n_d_word.chan[pab_pkg::CH_RED]   = r_c_src[23:16];
            n_d_word.chan[pab_pkg::CH_GREEN] = r_c_src[15:8];
            n_d_word.chan[pab_pkg::CH_BLUE]  = r_c_src[7:0];
            n_d_word.chan[pab_pkg::CH_ALPHA] = r_c_src[31:24];
        end else begin
            for (int c = 0; c < 3; c++) begin
                n_d_word.chan[c] = w_q[c][pab_pkg::DIV255_SHIFT +: 8];
            end
            n_d_word.chan[pab_pkg::CH_ALPHA] = pab_pkg::FULL_ALPHA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_rdy_c) r_c_valid <= i_valid;
            if (w_rdy_d) r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_c) begin
            r_c_sum   <= n_c_sum;
            r_c_src   <= i_word.src;
            r_c_alpha <= i_word.alpha;
        end
        if (w_rdy_d) r_d_word <= n_d_word;
    end

    assign o_valid = r_d_valid;
    assign o_word  = r_d_word;

endmodule

// ===== rtl/pab_pack.sv =====
module pab_pack (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pab_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_stall,
    input  pab_pkg::t_mix  i_word,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [31:0]    o_new_pixel,
    output logic           o_write_enable
);

    localparam int unsigned NC = pab_pkg::PAB_NCHAN;

    logic        r_e_valid;
    logic [14:0] r_e_t [NC];
    logic [7:0]  r_e_v [NC];
    logic        r_e_zero;
    logic        r_f_valid;
    logic [7:0]  r_f_q [NC];
    logic        r_f_zero;
    logic        r_o_valid;
    logic [31:0] r_o_pixel;
    logic        r_o_we;

    logic        w_rdy_e;
    logic        w_rdy_f;
    logic        w_rdy_o;
    logic [14:0] n_e_t [NC];
    logic [30:0] w_q [NC];
    logic [7:0]  n_f_q [NC];
    logic [31:0] n_o_pixel;

    assign w_rdy_o = !r_o_valid || !i_stall;
    assign w_rdy_f = !r_f_valid || w_rdy_o;
    assign w_rdy_e = !r_e_valid || w_rdy_f;
    assign o_stall = !w_rdy_e;

    always_comb begin
        n_o_pixel = 32'd0;
        for (int c = 0; c < NC; c++) begin
            n_e_t[c] = 15'(15'(i_word.chan[c]) * 15'(pab_pkg::chan_mask(i_cfg[c].bits)))
                     + 15'(pab_pkg::ROUND_HALF);
            w_q[c]   = 31'(r_e_t[c]) * 31'(pab_pkg::DIV255_MUL);
            if (i_cfg[c].bits[3]) begin
                n_f_q[c] = r_e_v[c];
            end else if (i_cfg[c].bits == 4'd0) begin
                n_f_q[c] = 8'd0;
            end else begin
                n_f_q[c] = w_q[c][pab_pkg::DIV255_SHIFT +: 8];
            end
            n_o_pixel = n_o_pixel | (32'(r_f_q[c]) << i_cfg[c].pos);
        end
        if (r_f_zero) n_o_pixel = 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_rdy_e) r_e_valid <= i_valid;
            if (w_rdy_f) r_f_valid <= r_e_valid;
            if (w_rdy_o) r_o_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_e) begin
            r_e_t    <= n_e_t;
            for (int c = 0; c < NC; c++) r_e_v[c] <= i_word.chan[c];
            r_e_zero <= i_word.zero;
        end
        if (w_rdy_f) begin
            r_f_q    <= n_f_q;
            r_f_zero <= r_e_zero;
        end
        if (w_rdy_o) begin
            r_o_pixel <= n_o_pixel;
            r_o_we    <= !r_f_zero;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_new_pixel    = r_o_pixel;
    assign o_write_enable = r_o_we;

endmodule

// ===== rtl/pixel_alpha_blend_top.sv =====
// Throughput: one word per cycle while i_stall is low; seven register stages,
//   each stage holds its word under output stall and stages upstream of a
//   bubble keep moving.
// Reset: synchronous, active low; clears all stage valid bits and loads the
//   layout registers with ARGB8888 (red 16, green 8, blue 0, alpha 24).
module pixel_alpha_blend_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_old_pixel,
    input  logic [31:0] i_src_color,
    input  logic [7:0]  i_blend_alpha,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_new_pixel,
    output logic        o_write_enable
);

    pab_pkg::t_cfg r_cfg;
    pab_pkg::t_cfg n_cfg;

    logic          w_u_valid;
    logic          w_u_stall;
    pab_pkg::t_unp w_u_word;
    logic          w_m_valid;
    logic          w_m_stall;
    pab_pkg::t_mix w_m_word;

    always_comb begin
        n_cfg = r_cfg;
        case (pab_pkg::t_reg_idx'(i_cfg_idx))
            pab_pkg::REG_RED_POS:    n_cfg[pab_pkg::CH_RED].pos    = i_cfg_data;
            pab_pkg::REG_RED_BITS:   n_cfg[pab_pkg::CH_RED].bits   = i_cfg_data[3:0];
            pab_pkg::REG_GREEN_POS:  n_cfg[pab_pkg::CH_GREEN].pos  = i_cfg_data;
            pab_pkg::REG_GREEN_BITS: n_cfg[pab_pkg::CH_GREEN].bits = i_cfg_data[3:0];
            pab_pkg::REG_BLUE_POS:   n_cfg[pab_pkg::CH_BLUE].pos   = i_cfg_data;
            pab_pkg::REG_BLUE_BITS:  n_cfg[pab_pkg::CH_BLUE].bits  = i_cfg_data[3:0];
            pab_pkg::REG_ALPHA_POS:  n_cfg[pab_pkg::CH_ALPHA].pos  = i_cfg_data;
            pab_pkg::REG_ALPHA_BITS: n_cfg[pab_pkg::CH_ALPHA].bits = i_cfg_data[3:0];
            default:                 n_cfg = r_cfg;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= pab_pkg::PAB_CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= n_cfg;
        end
    end

    pab_unpack u_unpack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_old_pixel   (i_old_pixel),
        .i_src_color   (i_src_color),
        .i_blend_alpha (i_blend_alpha),
        .o_valid       (w_u_valid),
        .i_stall       (w_u_stall),
        .o_word        (w_u_word)
    );

    pab_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_u_valid),
        .o_stall (w_u_stall),
        .i_word  (w_u_word),
        .o_valid (w_m_valid),
        .i_stall (w_m_stall),
        .o_word  (w_m_word)
    );

    pab_pack u_pack (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (w_m_valid),
        .o_stall        (w_m_stall),
        .i_word         (w_m_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_new_pixel    (o_new_pixel),
        .o_write_enable (o_write_enable)
    );

endmodule

// ===== rtl/pab_checker.sv =====
`include "assert_macros.svh"

module pab_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_new_pixel,
    input logic        o_write_enable
);

    `PAB_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
    `PAB_ASSERT(a_no_write_zero, i_clk, i_rst_n, o_valid && !o_write_enable |-> o_new_pixel == 32'd0, "nonzero pixel without write")
    `PAB_ASSERT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "word dropped under stall")
    `PAB_ASSERT(a_hold_word, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_new_pixel) && $stable(o_write_enable), "word changed under stall")

endmodule

bind pixel_alpha_blend_top pab_checker u_pab_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_new_pixel    (o_new_pixel),
    .o_write_enable (o_write_enable)
);
